>>> rtl/pal_sync_line_tracker_defines.svh
// Assertion macros used by the line tracker top level.
`ifndef PAL_SYNC_LINE_TRACKER_DEFINES_SVH
`define PAL_SYNC_LINE_TRACKER_DEFINES_SVH

// Implication checked at every clock edge, muted while reset is low.
`define PST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Plain property checked at every clock edge, muted while reset is low.
`define PST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

>>> rtl/pst_pkg.sv
// Types and constants of the PAL sync line tracker.
package pst_pkg;

  localparam int LINE_PIXELS = 256;
  localparam int FRAME_LINES = 625;
  localparam int LINE_SCALE  = LINE_PIXELS / 64;

  localparam int TS_W   = 32;
  localparam int CFG_W  = 32;
  localparam int PIX_W  = 8;
  localparam int LINE_W = 10;
  localparam int SSC_W  = 8;
  localparam int PROD_W = 2 * TS_W;
  localparam int Q_FRAC = 24;

  localparam int LINE_END_IDX = LINE_PIXELS - LINE_PIXELS / 5;
  localparam int SHORT_LO_IDX = LINE_PIXELS / 3;
  localparam int SHORT_HI_IDX = LINE_PIXELS - LINE_PIXELS / 3;
  localparam int SSC_MAX      = 255;

  localparam int FIELD1_LINE = 6;
  localparam int FIELD2_LINE = 318;
  localparam int ROW_SPLIT   = 313;
  localparam int LONG_MIN_US = 25;
  localparam int LONG_MAX_US = 35;

  typedef enum logic [1:0] {
    CFG_US_PER_TICK  = 2'd0,
    CFG_LINE_PERIOD  = 2'd1,
    CFG_SYNC_TIMEOUT = 2'd2
  } cfg_idx_e;

  // Timing of one event after the scaling multiplies.
  typedef struct packed {
    logic              fall;
    logic              rise;
    logic              skip;
    logic              luma;
    logic [PROD_W-1:0] idx_prod;
    logic [PROD_W-1:0] us_prod;
  } timing_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_x;
    logic [LINE_W-1:0] pixel_line;
    logic [LINE_W-1:0] screen_row;
    logic              pixel_white;
    logic              line_done;
    logic [LINE_W-1:0] done_line;
    logic              frame_start;
    logic              second_field;
    logic              vsync_error;
    logic              line_skipped;
  } result_t;

endpackage

>>> rtl/pst_front.sv
// Sync edge detection, sync start tracking and the tick scaling multiplies.
module pst_front import pst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load1_i,
  input  logic             load2_i,
  input  logic [TS_W-1:0]  timestamp_i,
  input  logic             sync_level_i,
  input  logic             luma_level_i,
  input  logic [CFG_W-1:0] us_per_tick_i,
  input  logic [CFG_W-1:0] line_period_i,
  input  logic [CFG_W-1:0] timeout_i,
  output timing_t          timing_o
);

  logic [TS_W-1:0] sync_start_q, sync_start_d;
  logic            prev_level_q;

  logic [TS_W-1:0] start_adj, start_skip, elapsed, since_sync;
  logic            skip, fall, rise;

  logic [TS_W-1:0] elapsed_q, since_q;
  logic            fall_q, rise_q, skip_q, luma_q;

  always_comb begin
    // advance past a timer rollover first
    start_adj  = (sync_start_q > timestamp_i) ? sync_start_q + line_period_i : sync_start_q;
    elapsed    = timestamp_i - start_adj;
    skip       = elapsed > timeout_i;
    start_skip = skip ? start_adj + line_period_i : start_adj;
    since_sync = timestamp_i - start_skip;
    fall       = prev_level_q & ~sync_level_i;
    rise       = ~prev_level_q & sync_level_i;
    sync_start_d = fall ? timestamp_i : start_skip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_start_q <= '0;
      prev_level_q <= 1'b0;
    end else if (load1_i) begin
      sync_start_q <= sync_start_d;
      prev_level_q <= sync_level_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load1_i) begin
      elapsed_q <= elapsed;
      since_q   <= since_sync;
      fall_q    <= fall;
      rise_q    <= rise;
      skip_q    <= skip;
      luma_q    <= luma_level_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load2_i) begin
      timing_o.fall     <= fall_q;
      timing_o.rise     <= rise_q;
      timing_o.skip     <= skip_q;
      timing_o.luma     <= luma_q;
      timing_o.idx_prod <= PROD_W'(elapsed_q) * PROD_W'(us_per_tick_i);
      timing_o.us_prod  <= PROD_W'(since_q) * PROD_W'(us_per_tick_i);
    end
  end

endmodule

>>> rtl/pst_line_ctrl.sv
// Line counting, short sync counting and field decision; result register.
module pst_line_ctrl import pst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  timing_t timing_i,
  output result_t res_o
);

  localparam int SCALE_W = $clog2(LINE_SCALE + 1);
  localparam int IDXS_W  = PROD_W + SCALE_W;
  localparam int IDX_W   = IDXS_W - Q_FRAC;
  localparam int US_W    = PROD_W - Q_FRAC;

  logic [SSC_W-1:0]  ssc_q, ssc_d;
  logic [SSC_W-1:0]  pssc_q, pssc_d;
  logic [LINE_W-1:0] line_q, line_d;

  logic [IDXS_W-1:0] idx_scaled;
  logic [IDX_W-1:0]  idx;
  logic [US_W-1:0]   us;
  logic              line_end, short_sync;
  logic [LINE_W-1:0] line_base;
  logic [LINE_W:0]   line_inc;
  logic [LINE_W:0]   row_wide;
  result_t           res_d;

  always_comb begin
    idx_scaled = IDXS_W'(timing_i.idx_prod) * IDXS_W'(LINE_SCALE);
    idx        = idx_scaled[IDXS_W-1:Q_FRAC];
    us         = timing_i.us_prod[PROD_W-1:Q_FRAC];
    line_end   = timing_i.fall && (idx > IDX_W'(LINE_END_IDX));
    short_sync = timing_i.fall && !line_end && (idx > IDX_W'(SHORT_LO_IDX)) &&
                 (idx < IDX_W'(SHORT_HI_IDX));

    ssc_d     = ssc_q;
    pssc_d    = pssc_q;
    line_d    = line_q;
    line_base = line_q;
    line_inc  = '0;
    res_d     = '0;

    if (line_end) begin
      if (ssc_q != '0) begin
        if (ssc_q > pssc_q) begin
          line_base         = LINE_W'(FIELD1_LINE);
          res_d.frame_start = 1'b1;
        end else if (ssc_q < pssc_q) begin
          line_base          = LINE_W'(FIELD2_LINE);
          res_d.second_field = 1'b1;
        end else begin
          res_d.vsync_error = 1'b1;
        end
        pssc_d = ssc_q;
        ssc_d  = '0;
      end
      res_d.line_done = 1'b1;
      res_d.done_line = line_base;
      line_inc        = {1'b0, line_base} + (LINE_W+1)'(1);
      line_d          = (line_inc >= (LINE_W+1)'(FRAME_LINES)) ? '0 : line_inc[LINE_W-1:0];
    end else if (short_sync && (ssc_q != SSC_W'(SSC_MAX))) begin
      ssc_d = ssc_q + SSC_W'(1);
    end

    // long sync ends between the two limits: drop the short sync run
    if (timing_i.rise && (us > US_W'(LONG_MIN_US)) && (us < US_W'(LONG_MAX_US))) begin
      ssc_d = '0;
    end

    if (line_end) begin
      res_d.pixel_x = '0;
    end else if (idx >= IDX_W'(LINE_PIXELS)) begin
      res_d.pixel_x = PIX_W'(LINE_PIXELS - 1);
    end else begin
      res_d.pixel_x = idx[PIX_W-1:0];
    end

    if (line_d < LINE_W'(ROW_SPLIT)) begin
      row_wide = {line_d, 1'b0};
    end else begin
      row_wide = {line_d - LINE_W'(ROW_SPLIT), 1'b1};
    end

    res_d.pixel_line   = line_d;
    res_d.screen_row   = row_wide[LINE_W-1:0];
    res_d.pixel_white  = timing_i.luma;
    res_d.line_skipped = timing_i.skip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssc_q  <= '0;
      pssc_q <= '0;
      line_q <= '0;
    end else if (load_i) begin
      ssc_q  <= ssc_d;
      pssc_q <= pssc_d;
      line_q <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_o <= res_d;
    end
  end

endmodule

>>> rtl/pal_sync_line_tracker.sv
// Top level of the PAL sync line tracker.
// Usage:
//   Event channel: in_valid_i with timestamp_i, sync_level_i and luma_level_i;
//   a transaction completes on a clock edge with in_valid_i high and
//   in_stall_o low. Result channel: out_valid_o with the pixel write fields;
//   a transaction completes with out_valid_o high and out_stall_i low.
//   Configuration: cfg_valid_i, cfg_index_i (0 us per tick Q8.24, 1 line
//   period, 2 sync timeout), cfg_data_i; cfg_ready_o is always high. Write
//   registers only while no event is in flight.
// Timing:
//   Three pipeline stages (edge detect and sync start, scaling multiplies,
//   line and field update). out_valid_o rises once an accepted event is held
//   in the last stage; one event per cycle is sustained while out_stall_i is
//   low. The two 32x32 multiplies sit in a stage of their own.
// Reset: clears the sync start time, sync level, short sync counts, line
//   number and all pipeline valid bits; registers return to their defaults.
// Stall: a stalled result holds; earlier stages keep filling, and in_stall_o
//   rises only once all three stages hold an item.
`include "pal_sync_line_tracker_defines.svh"

module pal_sync_line_tracker import pst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [TS_W-1:0]   timestamp_i,
  input  logic              sync_level_i,
  input  logic              luma_level_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PIX_W-1:0]  pixel_x_o,
  output logic [LINE_W-1:0] pixel_line_o,
  output logic [LINE_W-1:0] screen_row_o,
  output logic              pixel_white_o,
  output logic              line_done_o,
  output logic [LINE_W-1:0] done_line_o,
  output logic              frame_start_o,
  output logic              second_field_o,
  output logic              vsync_error_o,
  output logic              line_skipped_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  logic [CFG_W-1:0] us_per_tick_q, line_period_q, timeout_q;
  logic             v1_q, v2_q, v3_q;
  logic             en1, en2, en3, accept;
  timing_t          timing;
  result_t          res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      us_per_tick_q <= CFG_W'(32'h0100_0000);
      line_period_q <= CFG_W'(64);
      timeout_q     <= CFG_W'(70);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_US_PER_TICK:  us_per_tick_q <= cfg_data_i;
        CFG_LINE_PERIOD:  line_period_q <= cfg_data_i;
        CFG_SYNC_TIMEOUT: timeout_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // advance a stage when the one after it is empty or moving
  assign en3        = !v3_q || !out_stall_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;
  assign accept     = in_valid_i && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  pst_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load1_i       (accept),
    .load2_i       (en2 && v1_q),
    .timestamp_i   (timestamp_i),
    .sync_level_i  (sync_level_i),
    .luma_level_i  (luma_level_i),
    .us_per_tick_i (us_per_tick_q),
    .line_period_i (line_period_q),
    .timeout_i     (timeout_q),
    .timing_o      (timing)
  );

  pst_line_ctrl u_line_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (en3 && v2_q),
    .timing_i (timing),
    .res_o    (res)
  );

  assign out_valid_o    = v3_q;
  assign pixel_x_o      = res.pixel_x;
  assign pixel_line_o   = res.pixel_line;
  assign screen_row_o   = res.screen_row;
  assign pixel_white_o  = res.pixel_white;
  assign line_done_o    = res.line_done;
  assign done_line_o    = res.done_line;
  assign frame_start_o  = res.frame_start;
  assign second_field_o = res.second_field;
  assign vsync_error_o  = res.vsync_error;
  assign line_skipped_o = res.line_skipped;

  `PST_ASSERT_IMPL(a_stall_only_when_full, in_stall_o, out_valid_o && out_stall_i, "input stalled with room in the pipeline")
  `PST_ASSERT_IMPL(a_line_end_pixel_zero, out_valid_o && line_done_o, pixel_x_o == '0, "pixel index not cleared at line end")
  `PST_ASSERT_IMPL(a_field_needs_line_end, out_valid_o && (frame_start_o || second_field_o || vsync_error_o), line_done_o, "field decision without a line end")
  `PST_ASSERT_IMPL(a_line_in_frame, out_valid_o, pixel_line_o < LINE_W'(FRAME_LINES), "line number beyond frame")

endmodule

>>> dv/tb_pal_sync_line_tracker.sv
// Self-checking testbench for the PAL sync line tracker: predicted pixel writes vs. DUT results.
`timescale 1ns / 100ps

module tb_pal_sync_line_tracker;
  import pst_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RESET_CYC   = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYC   = 8;

  // Predicts one pixel write per pin-change event and checks results in order.
  class pixel_write_scoreboard;
    result_t          pending_writes[$];
    int               errors;
    int               n_events;
    int               n_checked;
    int               n_line_end;
    int               n_field1;
    int               n_field2;
    int               n_field_err;
    int               n_skip;
    int               n_roll;
    int               n_long_end;
    int               n_wrap;
    int               n_sat;
    logic [CFG_W-1:0] us_q24;
    logic [CFG_W-1:0] period;
    logic [CFG_W-1:0] timeout;
    logic [TS_W-1:0]  sync_t0;
    logic             sync_prev;
    logic [SSC_W-1:0] shorts;
    logic [SSC_W-1:0] shorts_prev;
    logic [LINE_W-1:0] line_no;

    function new();
      errors      = 0;
      n_events    = 0;
      n_checked   = 0;
      n_line_end  = 0;
      n_field1    = 0;
      n_field2    = 0;
      n_field_err = 0;
      n_skip      = 0;
      n_roll      = 0;
      n_long_end  = 0;
      n_wrap      = 0;
      n_sat       = 0;
      us_q24      = 32'h0100_0000;
      period      = 32'd64;
      timeout     = 32'd70;
      sync_t0     = '0;
      sync_prev   = 1'b0;
      shorts      = '0;
      shorts_prev = '0;
      line_no     = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_US_PER_TICK:  us_q24  = value;
        CFG_LINE_PERIOD:  period  = value;
        CFG_SYNC_TIMEOUT: timeout = value;
        default: ;
      endcase
    endfunction

    // floor(a * q / 2^24), split so no partial product overflows
    function logic [63:0] ticks_scaled(logic [63:0] a, logic [31:0] q);
      logic [63:0] hi;
      logic [63:0] lo;
      hi = a * {48'h0, q[31:16]};
      lo = a * {48'h0, q[15:0]};
      return (hi + (lo >> 16)) >> 8;
    endfunction

    function void note_event(logic [TS_W-1:0] t, logic s, logic l);
      result_t          r;
      logic [TS_W-1:0]  elapsed;
      logic [TS_W-1:0]  since_fall;
      logic [63:0]      pix;
      logic [63:0]      us;
      int               row;
      r = '0;
      n_events++;
      if (sync_t0 > t) begin
        sync_t0 = sync_t0 + period;
        n_roll++;
      end
      elapsed = t - sync_t0;
      pix = ticks_scaled(64'(elapsed) * 64'(LINE_SCALE), us_q24);
      // pixel index is taken before the timeout advance
      if (elapsed > timeout) begin
        sync_t0 = sync_t0 + period;
        r.line_skipped = 1'b1;
        n_skip++;
      end
      if (sync_prev && !s) begin
        sync_t0 = t;
        if (pix > LINE_END_IDX) begin
          if (shorts != 0) begin
            if (shorts > shorts_prev) begin
              line_no = LINE_W'(FIELD1_LINE);
              r.frame_start = 1'b1;
              n_field1++;
            end else if (shorts < shorts_prev) begin
              line_no = LINE_W'(FIELD2_LINE);
              r.second_field = 1'b1;
              n_field2++;
            end else begin
              r.vsync_error = 1'b1;
              n_field_err++;
            end
            shorts_prev = shorts;
            shorts = '0;
          end
          r.line_done = 1'b1;
          r.done_line = line_no;
          n_line_end++;
          if (int'(line_no) + 1 >= FRAME_LINES) begin
            line_no = '0;
            n_wrap++;
          end else begin
            line_no = line_no + 1'b1;
          end
          pix = '0;
        end else if (pix > SHORT_LO_IDX && pix < SHORT_HI_IDX) begin
          if (shorts != SSC_MAX) shorts = shorts + 1'b1;
          else n_sat++;
        end
      end
      if (!sync_prev && s) begin
        since_fall = t - sync_t0;
        us = ticks_scaled(64'(since_fall), us_q24);
        if (us > LONG_MIN_US && us < LONG_MAX_US) begin
          shorts = '0;
          n_long_end++;
        end
      end
      if (pix >= LINE_PIXELS) pix = 64'(LINE_PIXELS - 1);
      sync_prev = s;
      row = (int'(line_no) < ROW_SPLIT) ? int'(line_no) * 2 : (int'(line_no) - ROW_SPLIT) * 2 + 1;
      r.pixel_x     = pix[PIX_W-1:0];
      r.pixel_line  = line_no;
      r.screen_row  = row[LINE_W-1:0];
      r.pixel_white = l;
      pending_writes.push_back(r);
    endfunction

    function void match(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_write(result_t got);
      result_t want;
      if (pending_writes.size() == 0) begin
        $error("pixel write with no pending event: pixel_x %0d line %0d",
               got.pixel_x, got.pixel_line);
        errors++;
        return;
      end
      want = pending_writes.pop_front();
      n_checked++;
      match("pixel_x",      32'(want.pixel_x),      32'(got.pixel_x));
      match("pixel_line",   32'(want.pixel_line),   32'(got.pixel_line));
      match("screen_row",   32'(want.screen_row),   32'(got.screen_row));
      match("pixel_white",  32'(want.pixel_white),  32'(got.pixel_white));
      match("line_done",    32'(want.line_done),    32'(got.line_done));
      match("done_line",    32'(want.done_line),    32'(got.done_line));
      match("frame_start",  32'(want.frame_start),  32'(got.frame_start));
      match("second_field", 32'(want.second_field), 32'(got.second_field));
      match("vsync_error",  32'(want.vsync_error),  32'(got.vsync_error));
      match("line_skipped", 32'(want.line_skipped), 32'(got.line_skipped));
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [TS_W-1:0]   timestamp  = '0;
  logic              sync_level = 1'b0;
  logic              luma_level = 1'b0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [PIX_W-1:0]  pixel_x;
  logic [LINE_W-1:0] pixel_line;
  logic [LINE_W-1:0] screen_row;
  logic              pixel_white;
  logic              line_done;
  logic [LINE_W-1:0] done_line;
  logic              frame_start;
  logic              second_field;
  logic              vsync_error;
  logic              line_skipped;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index  = '0;
  logic [CFG_W-1:0]  cfg_data   = '0;

  pixel_write_scoreboard sb = new();

  int                idle_pct  = 0;
  int                stall_pct = 0;
  int                tpu       = 1;
  int                n_sent    = 0;
  logic [TS_W-1:0]   now_t     = '0;

  pal_sync_line_tracker DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .timestamp_i    (timestamp),
    .sync_level_i   (sync_level),
    .luma_level_i   (luma_level),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_x_o      (pixel_x),
    .pixel_line_o   (pixel_line),
    .screen_row_o   (screen_row),
    .pixel_white_o  (pixel_white),
    .line_done_o    (line_done),
    .done_line_o    (done_line),
    .frame_start_o  (frame_start),
    .second_field_o (second_field),
    .vsync_error_o  (vsync_error),
    .line_skipped_o (line_skipped),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin : result_monitor
    result_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.pixel_x      = pixel_x;
      seen.pixel_line   = pixel_line;
      seen.screen_row   = screen_row;
      seen.pixel_white  = pixel_white;
      seen.line_done    = line_done;
      seen.done_line    = done_line;
      seen.frame_start  = frame_start;
      seen.second_field = second_field;
      seen.vsync_error  = vsync_error;
      seen.line_skipped = line_skipped;
      sb.check_write(seen);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // Leaves in_valid high after the transaction; the next call or the caller drops it.
  task automatic push_event(logic [TS_W-1:0] t, logic s, logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    timestamp  <= t;
    sync_level <= s;
    luma_level <= l;
    do @(posedge clk); while (in_stall);
    sb.note_event(t, s, l);
    n_sent++;
  endtask

  task automatic put_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
  endtask

  task automatic load_timing(logic [CFG_W-1:0] q, logic [CFG_W-1:0] lp, logic [CFG_W-1:0] to);
    in_valid <= 1'b0;
    // drain the pipeline before touching the registers
    while (sb.pending_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    put_reg(CFG_US_PER_TICK, q);
    put_reg(CFG_LINE_PERIOD, lp);
    put_reg(CFG_SYNC_TIMEOUT, to);
    cfg_valid <= 1'b0;
  endtask

  // One line: sync fall, sync rise after 4 us, then luma changes spread over the line.
  task automatic hsync_line(int len_us, int n_luma);
    logic [TS_W-1:0] t0;
    int              slot;
    int              off;
    t0 = now_t;
    push_event(t0, 1'b0, 1'b0);
    push_event(t0 + 4 * tpu, 1'b1, 1'($urandom_range(1)));
    if (n_luma > 0) begin
      slot = ((len_us - 6) * tpu) / n_luma;
      for (int i = 0; i < n_luma; i++) begin
        off = 5 * tpu + i * slot + $urandom_range(slot - 1, 0);
        push_event(t0 + off, 1'b1, 1'($urandom_range(1)));
      end
    end
    now_t = t0 + len_us * tpu;
  endtask

  // Half-line pulses: the first fall ends the line, the rest count as short syncs.
  task automatic short_group(int k);
    for (int i = 0; i < k; i++) begin
      push_event(now_t, 1'b0, 1'b0);
      push_event(now_t + 2 * tpu, 1'b1, 1'($urandom_range(1)));
      now_t = now_t + 32 * tpu;
    end
    now_t = now_t + 32 * tpu;
  endtask

  // Broad pulses with their rise spread across the long-sync window edges.
  task automatic long_group(int k);
    for (int i = 0; i < k; i++) begin
      push_event(now_t, 1'b0, 1'b0);
      push_event(now_t + $urandom_range(24, 36) * tpu, 1'b1, 1'b0);
      now_t = now_t + 40 * tpu;
    end
  endtask

  task automatic noise(int k);
    logic [TS_W-1:0] t;
    for (int i = 0; i < k; i++) begin
      t = $urandom_range(1) ? $urandom : now_t + $urandom_range(100 * tpu, 0);
      push_event(t, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic random_traffic(int n);
    int stop_at;
    int pick;
    stop_at = n_sent + n;
    while (n_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40)      hsync_line(64, $urandom_range(3, 0));
      else if (pick < 56) short_group($urandom_range(3, 8));
      else if (pick < 64) long_group($urandom_range(1, 5));
      else if (pick < 72) hsync_line($urandom_range(65, 200), $urandom_range(1, 3));
      else if (pick < 80) hsync_line($urandom_range(20, 63), $urandom_range(3, 0));
      else if (pick < 86) now_t = 32'hFFFF_FFFF - $urandom_range(150 * tpu, 0);
      else                noise($urandom_range(1, 4));
    end
  endtask

  // Walk the corners at reset timing: rollover, timeout, shorts, both fields,
  // equal counts and a long sync end.
  task automatic directed_events();
    logic [TS_W-1:0] d_ts[20];
    logic            d_sync[20];
    logic            d_luma[20];
    d_ts   = '{32'd0, 32'hFFFF_FFFF, 32'd5, 32'd9, 32'd37, 32'd39, 32'd69, 32'd71,
               32'd133, 32'd137, 32'd169, 32'd199, 32'd201, 32'd203, 32'd265, 32'd267,
               32'd299, 32'd301, 32'd363, 32'd365};
    d_sync = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
               1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    d_luma = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
               1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
    for (int i = 0; i < 20; i++) push_event(d_ts[i], d_sync[i], d_luma[i]);
    now_t = 32'd427;
  endtask

  initial begin
    logic [CFG_W-1:0] q_tab[8];
    logic [CFG_W-1:0] lp_tab[8];
    logic [CFG_W-1:0] to_tab[8];
    int               tpu_tab[8];
    q_tab   = '{32'h0100_0000, 32'h0080_0000, 32'h0040_0000, 32'hFFFF_FFFF,
                32'h0000_0001, 32'h0100_0000, 32'h0100_0000, 32'h0080_0000};
    lp_tab  = '{32'd64, 32'd128, 32'd256, 32'hFFFF_FFFF, 32'd1, 32'd64, 32'd64, 32'd128};
    to_tab  = '{32'd70, 32'd140, 32'd280, 32'd1, 32'hFFFF_FFFF, 32'd70, 32'd70, 32'd140};
    tpu_tab = '{1, 2, 4, 1, 1, 1, 1, 2};
    q_tab[5]  = $urandom_range(32'h0200_0000, 32'h0080_0000);
    lp_tab[5] = $urandom_range(1, 200);
    to_tab[5] = $urandom_range(1, 200);

    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_events();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      load_timing(q_tab[p], lp_tab[p], to_tab[p]);
      tpu = tpu_tab[p];
      if (p == 0) begin
        // force the second field, then run plain lines past the last frame line
        hsync_line(64, 0);
        short_group(7);
        hsync_line(64, 0);
        short_group(3);
        repeat (310) hsync_line(64, 0);
      end
      random_traffic(28);
    end

    in_valid <= 1'b0;
    while (sb.pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("covered %0d events, %0d writes checked; line ends %0d, field one %0d, field two %0d, undecided %0d",
             sb.n_events, sb.n_checked, sb.n_line_end, sb.n_field1, sb.n_field2,
             sb.n_field_err);
    $display("sync timeouts %0d, timer rollovers %0d, long sync ends %0d, frame wraps %0d, saturated shorts %0d",
             sb.n_skip, sb.n_roll, sb.n_long_end, sb.n_wrap, sb.n_sat);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

>>> pal_sync_line_tracker.f
+incdir+rtl
rtl/pst_pkg.sv
rtl/pst_front.sv
rtl/pst_line_ctrl.sv
rtl/pal_sync_line_tracker.sv
dv/tb_pal_sync_line_tracker.sv
